// ----- rtl/core/lrn_pkg.sv -----
// Shared types, widths and codes for the letterbox resize / normalize block.
// Used by the channel interfaces, the top level and the port checker.
package lrn_pkg;

    localparam int MAX_TARGET = 1024;
    localparam int MAX_SOURCE = 4096;
    localparam int FRAC_BITS  = 16;

    // Field and register widths fixed by the external interface
    localparam int CMD_W    = 2;
    localparam int PIX_W    = 8;
    localparam int SRC_W    = 13;
    localparam int TGT_W    = 11;
    localparam int CNT_W    = 10;
    localparam int FETCH_W  = 12;
    localparam int IMG_W    = 11;
    localparam int INV_W    = 29;
    localparam int ACC_W    = 39;
    localparam int SCALE_W  = 27;
    localparam int OFFSET_W = 26;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Shared divider sizing: widest dividend is (T*(m-side) << FRAC_BITS) + m
    localparam int PROD_W     = SRC_W + TGT_W;
    localparam int DIVIDEND_W = $clog2(MAX_TARGET) + $clog2(MAX_SOURCE) + FRAC_BITS + 1;
    localparam int DIVISOR_W  = $clog2(MAX_SOURCE) + 2;
    localparam int STEP_W     = $clog2(DIVIDEND_W + 1);

    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WALK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SIDE   = 2'd2;

    localparam logic [SRC_W-1:0] SOURCE_WIDTH_RST  = 13'd640;
    localparam logic [SRC_W-1:0] SOURCE_HEIGHT_RST = 13'd480;
    localparam logic [TGT_W-1:0] TARGET_SIDE_RST   = 11'd640;

    localparam logic [PIX_W-1:0] PIX_BIAS = 8'h80;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [PIX_W-1:0] pix_red;
        logic [PIX_W-1:0] pix_green;
        logic [PIX_W-1:0] pix_blue;
    } lrn_req_t;

    typedef struct packed {
        logic [CNT_W-1:0]        dest_x;
        logic [CNT_W-1:0]        dest_y;
        logic                    is_pad;
        logic [FETCH_W-1:0]      fetch_x;
        logic [FETCH_W-1:0]      fetch_y;
        logic                    last;
        logic signed [PIX_W-1:0] norm_red;
        logic signed [PIX_W-1:0] norm_green;
        logic signed [PIX_W-1:0] norm_blue;
        logic [SCALE_W-1:0]      scale_q16;
        logic [OFFSET_W-1:0]     offset_x_q16;
        logic [OFFSET_W-1:0]     offset_y_q16;
    } lrn_rsp_t;

    // zero reads as one, above the limit reads as the limit
    function automatic logic [SRC_W-1:0] eff_source(input logic [SRC_W-1:0] raw);
        logic [SRC_W-1:0] v;
        begin
            v = raw;
            if (raw == '0)
            begin
                v = SRC_W'(1);
            end
            else if (raw > SRC_W'(MAX_SOURCE))
            begin
                v = SRC_W'(MAX_SOURCE);
            end
            return v;
        end
    endfunction

    function automatic logic [TGT_W-1:0] eff_target(input logic [TGT_W-1:0] raw);
        logic [TGT_W-1:0] v;
        begin
            v = raw;
            if (raw == '0)
            begin
                v = TGT_W'(1);
            end
            else if (raw > TGT_W'(MAX_TARGET))
            begin
                v = TGT_W'(MAX_TARGET);
            end
            return v;
        end
    endfunction

endpackage

// ----- rtl/core/lrn_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
// Depends on lrn_pkg for the payload types.
interface lrn_req_if;
    logic              valid;
    logic              ready;
    lrn_pkg::lrn_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lrn_rsp_if;
    logic              valid;
    logic              ready;
    lrn_pkg::lrn_rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/letterbox_resize_normalize_unit.sv -----
// Letterbox nearest-neighbor resampler with pixel normalization.
// Depends on lrn_pkg and the lrn_req_if / lrn_rsp_if channel interfaces.
//
// Usage:
//   req carries one command per beat: START opens a frame, WALK steps one
//   destination pixel in raster order, DATA turns a fetched RGB pixel into
//   signed values (pad pixels give -128). Command 3 is dropped with no beat.
//   rsp carries one beat per START, WALK and DATA; unused fields are zero.
//   cfg_we/cfg_index/cfg_data write source width, source height and target
//   side; write only while the block is idle.
// Timing:
//   WALK and DATA: result registered, on rsp the cycle after acceptance,
//   one command per cycle while no rsp beat is held.
//   START: six divisions run in turn on one shared restoring divider, one
//   quotient bit per cycle, each with a load and a store step; after the last
//   store the result is registered on rsp once it is free; req.ready is low meanwhile.
// Reset: registers go to 640 x 480 source, 640 side; the walk state clears
//   and every pixel reads as pad until the first START.
// Stall: a held rsp beat keeps req.ready low until it is taken.
module letterbox_resize_normalize_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    lrn_req_if.sink                       req,
    lrn_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [lrn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lrn_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_STORE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [2:0] OP_IMG_W  = 3'd0;
    localparam logic [2:0] OP_IMG_H  = 3'd1;
    localparam logic [2:0] OP_INV    = 3'd2;
    localparam logic [2:0] OP_SCALE  = 3'd3;
    localparam logic [2:0] OP_OFF_X  = 3'd4;
    localparam logic [2:0] OP_OFF_Y  = 3'd5;

    // configuration
    logic [lrn_pkg::SRC_W-1:0] src_w_reg;
    logic [lrn_pkg::SRC_W-1:0] src_h_reg;
    logic [lrn_pkg::TGT_W-1:0] tgt_reg;

    // sequencer and shared divider
    logic [2:0]                       state_reg, state_next;
    logic [2:0]                       op_reg;
    logic [lrn_pkg::STEP_W-1:0]       step_reg;
    logic [lrn_pkg::DIVIDEND_W-1:0]   dq_reg;
    logic [lrn_pkg::DIVISOR_W-1:0]    rem_reg;
    logic [lrn_pkg::DIVISOR_W-1:0]    dvsr_reg;

    // operands latched at frame start
    logic [lrn_pkg::SRC_W-1:0] sw_reg;
    logic [lrn_pkg::SRC_W-1:0] sh_reg;
    logic [lrn_pkg::SRC_W-1:0] m_reg;
    logic [lrn_pkg::TGT_W-1:0] t_reg;

    // frame results
    logic [lrn_pkg::IMG_W-1:0]    img_w_reg;
    logic [lrn_pkg::IMG_W-1:0]    img_h_reg;
    logic [lrn_pkg::CNT_W-1:0]    left_pad_reg;
    logic [lrn_pkg::CNT_W-1:0]    top_pad_reg;
    logic [lrn_pkg::INV_W-1:0]    inv_reg;
    logic [lrn_pkg::SCALE_W-1:0]  scale_reg;
    logic [lrn_pkg::OFFSET_W-1:0] off_x_reg;
    logic [lrn_pkg::OFFSET_W-1:0] off_y_reg;

    // walk state
    logic [lrn_pkg::CNT_W-1:0] col_cnt_reg;
    logic [lrn_pkg::CNT_W-1:0] row_cnt_reg;
    logic [lrn_pkg::ACC_W-1:0] col_acc_reg;
    logic [lrn_pkg::ACC_W-1:0] row_acc_reg;
    logic                      pending_pad_reg;

    // output stage
    logic              rsp_valid_reg;
    lrn_pkg::lrn_rsp_t rsp_reg;
    lrn_pkg::lrn_rsp_t rsp_next;
    logic              rsp_load;

    logic              accept;
    logic              out_free;
    logic [lrn_pkg::SRC_W-1:0] sw_eff;
    logic [lrn_pkg::SRC_W-1:0] sh_eff;
    logic [lrn_pkg::TGT_W-1:0] t_eff;

    assign sw_eff = lrn_pkg::eff_source(src_w_reg);
    assign sh_eff = lrn_pkg::eff_source(src_h_reg);
    assign t_eff  = lrn_pkg::eff_target(tgt_reg);

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= lrn_pkg::SOURCE_WIDTH_RST;
            src_h_reg <= lrn_pkg::SOURCE_HEIGHT_RST;
            tgt_reg   <= lrn_pkg::TARGET_SIDE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lrn_pkg::REG_SOURCE_WIDTH:  src_w_reg <= cfg_data;
                lrn_pkg::REG_SOURCE_HEIGHT: src_h_reg <= cfg_data;
                lrn_pkg::REG_TARGET_SIDE:   tgt_reg   <= cfg_data[lrn_pkg::TGT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- shared multiplier and divider operands ----------------
    logic [lrn_pkg::SRC_W-1:0]      mul_a;
    logic [lrn_pkg::PROD_W-1:0]     prod;
    logic [lrn_pkg::DIVIDEND_W-1:0] dividend_ld;
    logic [lrn_pkg::DIVISOR_W-1:0]  divisor_ld;

    always_comb
    begin
        case (op_reg)
            OP_IMG_W: mul_a = sw_reg;
            OP_IMG_H: mul_a = sh_reg;
            OP_OFF_X: mul_a = m_reg - sw_reg;
            OP_OFF_Y: mul_a = m_reg - sh_reg;
            default:  mul_a = '0;
        endcase
    end

    assign prod = lrn_pkg::PROD_W'(mul_a) * lrn_pkg::PROD_W'(t_reg);

    always_comb
    begin
        case (op_reg)
            OP_IMG_W, OP_IMG_H:
            begin
                dividend_ld = lrn_pkg::DIVIDEND_W'(prod);
                divisor_ld  = lrn_pkg::DIVISOR_W'(m_reg);
            end
            OP_INV:
            begin
                dividend_ld = lrn_pkg::DIVIDEND_W'(m_reg) << lrn_pkg::FRAC_BITS;
                divisor_ld  = lrn_pkg::DIVISOR_W'(t_reg);
            end
            OP_SCALE:
            begin
                // round to nearest: add half the divisor
                dividend_ld = (lrn_pkg::DIVIDEND_W'(t_reg) << lrn_pkg::FRAC_BITS)
                            + lrn_pkg::DIVIDEND_W'(m_reg >> 1);
                divisor_ld  = lrn_pkg::DIVISOR_W'(m_reg);
            end
            OP_OFF_X, OP_OFF_Y:
            begin
                // (T*(m-side)/(2m)) rounded: numerator + m over 2m
                dividend_ld = (lrn_pkg::DIVIDEND_W'(prod) << lrn_pkg::FRAC_BITS)
                            + lrn_pkg::DIVIDEND_W'(m_reg);
                divisor_ld  = {1'b0, m_reg} << 1;
            end
            default:
            begin
                dividend_ld = '0;
                divisor_ld  = lrn_pkg::DIVISOR_W'(1);
            end
        endcase
    end

    // one restoring step per cycle
    logic [lrn_pkg::DIVISOR_W:0] trial;
    logic                        trial_ge;

    assign trial    = {rem_reg, dq_reg[lrn_pkg::DIVIDEND_W-1]};
    assign trial_ge = trial >= {1'b0, dvsr_reg};

    // ---------------- walk datapath ----------------
    logic                          in_col;
    logic                          in_row;
    logic                          walk_pad;
    logic                          end_row;
    logic                          walk_last;
    logic [lrn_pkg::CNT_W+1:0]     col_end;
    logic [lrn_pkg::CNT_W+1:0]     row_end;
    logic [lrn_pkg::TGT_W-1:0]     col_inc;
    logic [lrn_pkg::TGT_W-1:0]     row_inc;
    logic [lrn_pkg::SRC_W-1:0]     sw_max;
    logic [lrn_pkg::SRC_W-1:0]     sh_max;
    logic [lrn_pkg::ACC_W-lrn_pkg::FRAC_BITS-1:0] fx_raw;
    logic [lrn_pkg::ACC_W-lrn_pkg::FRAC_BITS-1:0] fy_raw;
    logic [lrn_pkg::FETCH_W-1:0]   fetch_x;
    logic [lrn_pkg::FETCH_W-1:0]   fetch_y;

    assign col_end = (lrn_pkg::CNT_W+2)'(left_pad_reg) + (lrn_pkg::CNT_W+2)'(img_w_reg);
    assign row_end = (lrn_pkg::CNT_W+2)'(top_pad_reg) + (lrn_pkg::CNT_W+2)'(img_h_reg);
    assign in_col  = (col_cnt_reg >= left_pad_reg)
                  && ((lrn_pkg::CNT_W+2)'(col_cnt_reg) < col_end);
    assign in_row  = (row_cnt_reg >= top_pad_reg)
                  && ((lrn_pkg::CNT_W+2)'(row_cnt_reg) < row_end);
    assign walk_pad = !(in_col && in_row);

    assign col_inc   = lrn_pkg::TGT_W'(col_cnt_reg) + lrn_pkg::TGT_W'(1);
    assign row_inc   = lrn_pkg::TGT_W'(row_cnt_reg) + lrn_pkg::TGT_W'(1);
    assign end_row   = col_inc >= t_eff;
    assign walk_last = end_row && (row_inc >= t_eff);

    assign sw_max = sw_eff - lrn_pkg::SRC_W'(1);
    assign sh_max = sh_eff - lrn_pkg::SRC_W'(1);
    assign fx_raw = col_acc_reg[lrn_pkg::ACC_W-1:lrn_pkg::FRAC_BITS];
    assign fy_raw = row_acc_reg[lrn_pkg::ACC_W-1:lrn_pkg::FRAC_BITS];

    always_comb
    begin
        fetch_x = '0;
        fetch_y = '0;
        if (!walk_pad)
        begin
            if (fx_raw > ($bits(fx_raw))'(sw_max))
                fetch_x = sw_max[lrn_pkg::FETCH_W-1:0];
            else
                fetch_x = fx_raw[lrn_pkg::FETCH_W-1:0];
            if (fy_raw > ($bits(fy_raw))'(sh_max))
                fetch_y = sh_max[lrn_pkg::FETCH_W-1:0];
            else
                fetch_y = fy_raw[lrn_pkg::FETCH_W-1:0];
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.payload.cmd == lrn_pkg::CMD_START)
                    state_next = ST_LOAD;
            end
            ST_LOAD:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (step_reg == lrn_pkg::STEP_W'(lrn_pkg::DIVIDEND_W - 1))
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                if (op_reg == OP_OFF_Y)
                    state_next = ST_DONE;
                else
                    state_next = ST_LOAD;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_IMG_W;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:  op_reg <= OP_IMG_W;
                ST_LOAD:  step_reg <= '0;
                ST_DIV:   step_reg <= step_reg + lrn_pkg::STEP_W'(1);
                ST_STORE: op_reg <= op_reg + 3'd1;
                default: ;
            endcase
        end
    end

    // divider datapath and start operands
    always_ff @(posedge clk)
    begin
        if (accept && req.payload.cmd == lrn_pkg::CMD_START)
        begin
            sw_reg <= sw_eff;
            sh_reg <= sh_eff;
            m_reg  <= (sw_eff > sh_eff) ? sw_eff : sh_eff;
            t_reg  <= t_eff;
        end
        if (state_reg == ST_LOAD)
        begin
            dq_reg   <= dividend_ld;
            rem_reg  <= '0;
            dvsr_reg <= divisor_ld;
        end
        else if (state_reg == ST_DIV)
        begin
            dq_reg  <= {dq_reg[lrn_pkg::DIVIDEND_W-2:0], trial_ge};
            rem_reg <= trial_ge ? lrn_pkg::DIVISOR_W'(trial - {1'b0, dvsr_reg})
                                : lrn_pkg::DIVISOR_W'(trial);
        end
    end

    // frame results and walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg       <= '0;
            img_h_reg       <= '0;
            left_pad_reg    <= '0;
            top_pad_reg     <= '0;
            inv_reg         <= '0;
            scale_reg       <= '0;
            off_x_reg       <= '0;
            off_y_reg       <= '0;
            col_cnt_reg     <= '0;
            row_cnt_reg     <= '0;
            col_acc_reg     <= '0;
            row_acc_reg     <= '0;
            pending_pad_reg <= 1'b1;
        end
        else
        begin
            if (state_reg == ST_STORE)
            begin
                case (op_reg)
                    OP_IMG_W: img_w_reg <= dq_reg[lrn_pkg::IMG_W-1:0];
                    OP_IMG_H: img_h_reg <= dq_reg[lrn_pkg::IMG_W-1:0];
                    OP_INV:   inv_reg   <= dq_reg[lrn_pkg::INV_W-1:0];
                    OP_SCALE: scale_reg <= dq_reg[lrn_pkg::SCALE_W-1:0];
                    OP_OFF_X: off_x_reg <= dq_reg[lrn_pkg::OFFSET_W-1:0];
                    OP_OFF_Y:
                    begin
                        off_y_reg    <= dq_reg[lrn_pkg::OFFSET_W-1:0];
                        // image size already settled by now
                        left_pad_reg <= lrn_pkg::CNT_W'(lrn_pkg::TGT_W'(t_reg - img_w_reg) >> 1);
                        top_pad_reg  <= lrn_pkg::CNT_W'(lrn_pkg::TGT_W'(t_reg - img_h_reg) >> 1);
                    end
                    default: ;
                endcase
            end

            if (accept && req.payload.cmd == lrn_pkg::CMD_START)
            begin
                col_cnt_reg     <= '0;
                row_cnt_reg     <= '0;
                col_acc_reg     <= '0;
                row_acc_reg     <= '0;
                pending_pad_reg <= 1'b1;
            end
            else if (accept && req.payload.cmd == lrn_pkg::CMD_WALK)
            begin
                pending_pad_reg <= walk_pad;
                if (end_row)
                begin
                    col_cnt_reg <= '0;
                    col_acc_reg <= '0;
                    if (walk_last)
                    begin
                        row_cnt_reg <= '0;
                        row_acc_reg <= '0;
                    end
                    else
                    begin
                        row_cnt_reg <= row_cnt_reg + lrn_pkg::CNT_W'(1);
                        if (in_row)
                            row_acc_reg <= row_acc_reg + lrn_pkg::ACC_W'(inv_reg);
                    end
                end
                else
                begin
                    col_cnt_reg <= col_cnt_reg + lrn_pkg::CNT_W'(1);
                    if (in_col)
                        col_acc_reg <= col_acc_reg + lrn_pkg::ACC_W'(inv_reg);
                end
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept && (req.payload.cmd == lrn_pkg::CMD_WALK
                         || req.payload.cmd == lrn_pkg::CMD_DATA))
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_load = (accept && (req.payload.cmd == lrn_pkg::CMD_WALK
                               || req.payload.cmd == lrn_pkg::CMD_DATA))
                   || (state_reg == ST_DONE && out_free);

    // accepts happen only in idle, so the start result never collides
    always_comb
    begin
        rsp_next = '0;
        if (state_reg == ST_DONE)
        begin
            rsp_next.scale_q16    = scale_reg;
            rsp_next.offset_x_q16 = off_x_reg;
            rsp_next.offset_y_q16 = off_y_reg;
        end
        else if (req.payload.cmd == lrn_pkg::CMD_WALK)
        begin
            rsp_next.dest_x  = col_cnt_reg;
            rsp_next.dest_y  = row_cnt_reg;
            rsp_next.is_pad  = walk_pad;
            rsp_next.fetch_x = fetch_x;
            rsp_next.fetch_y = fetch_y;
            rsp_next.last    = walk_last;
        end
        else if (req.payload.cmd == lrn_pkg::CMD_DATA)
        begin
            if (pending_pad_reg)
            begin
                rsp_next.norm_red   = lrn_pkg::PIX_BIAS;
                rsp_next.norm_green = lrn_pkg::PIX_BIAS;
                rsp_next.norm_blue  = lrn_pkg::PIX_BIAS;
            end
            else
            begin
                // flipping the top bit subtracts 128 into two's complement
                rsp_next.norm_red   = req.payload.pix_red ^ lrn_pkg::PIX_BIAS;
                rsp_next.norm_green = req.payload.pix_green ^ lrn_pkg::PIX_BIAS;
                rsp_next.norm_blue  = req.payload.pix_blue ^ lrn_pkg::PIX_BIAS;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ----- rtl/core/lrn_checker.sv -----
// Port-level checks for letterbox_resize_normalize_unit, attached by bind.
// Depends on lrn_pkg for codes and payload types.
module lrn_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input lrn_pkg::lrn_req_t req_payload,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input lrn_pkg::lrn_rsp_t rsp_payload
);

    logic req_beat;

    assign req_beat = req_valid && req_ready;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
        else $error("rsp beat dropped or changed while stalled");

    a_stall_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("req accepted while rsp stalled");

    a_walk_data_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_beat && (req_payload.cmd == lrn_pkg::CMD_WALK
                  || req_payload.cmd == lrn_pkg::CMD_DATA) |=> rsp_valid)
        else $error("walk or data beat gave no result next cycle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_beat && req_payload.cmd == lrn_pkg::CMD_START |=> !req_ready)
        else $error("req ready right after frame start");

    a_pad_no_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.is_pad |->
            rsp_payload.fetch_x == '0 && rsp_payload.fetch_y == '0)
        else $error("pad pixel carries a fetch address");

endmodule

bind letterbox_resize_normalize_unit lrn_checker u_lrn_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_payload (req.payload),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);

// ----- bench/tb_letterbox_resize_normalize_unit.sv -----
// Self-checking bench for letterbox_resize_normalize_unit: directed table, then random frames.
// Needs lrn_pkg, the lrn_req_if / lrn_rsp_if channel interfaces and the unit itself.
// Every response beat is checked field by field against an in-bench resampler model or a directed row's expected value.
module tb_letterbox_resize_normalize_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import lrn_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RAND_ITEMS   = 450;
    localparam int SETTLE_CYC   = 8;
    localparam int HOLD_CYC     = 150;
    localparam int RUN_LIMIT_NS = 1_500_000;

    typedef enum logic {ROW_CMD, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e             kind;
        lrn_req_t              item;
        logic [2:0]            mask;
        logic [CFG_DATA_W-1:0] w_val;
        logic [CFG_DATA_W-1:0] h_val;
        logic [CFG_DATA_W-1:0] t_val;
        bit                    typed;
        lrn_rsp_t              want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lrn_req_if req_ch ();
    lrn_rsp_if rsp_ch ();

    letterbox_resize_normalize_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies and resampler state
    logic [SRC_W-1:0] reg_w;
    logic [SRC_W-1:0] reg_h;
    logic [TGT_W-1:0] reg_t;
    logic [IMG_W-1:0] img_w;
    logic [IMG_W-1:0] img_h;
    logic [CNT_W-1:0] pad_left;
    logic [CNT_W-1:0] pad_top;
    logic [INV_W-1:0] inv_step;
    logic [CNT_W-1:0] col_n;
    logic [CNT_W-1:0] row_n;
    logic [ACC_W-1:0] col_acc;
    logic [ACC_W-1:0] row_acc;
    bit               pad_latch;

    lrn_rsp_t due_rsp_q [$];
    int  err_count;
    int  rsp_beats;
    int  n_start;
    int  n_walk;
    int  n_data;
    int  n_phase;
    int  rx_hold_cycles;
    bit  no_idle;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("timeout at %0t, %0d results still due", $time, due_rsp_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint unsigned dim_eff(input longint unsigned raw,
                                                input longint unsigned lim);
        if (raw == 0)
        begin
            return 1;
        end
        return (raw > lim) ? lim : raw;
    endfunction

    function automatic bit resample_predict(input lrn_req_t it, output lrn_rsp_t r);
        longint unsigned sw, sh, t, m, x, y, fx, fy;
        bit in_col, in_row, pad, end_row, at_last;
        sw = dim_eff(reg_w, MAX_SOURCE);
        sh = dim_eff(reg_h, MAX_SOURCE);
        t  = dim_eff(reg_t, MAX_TARGET);
        r  = '0;
        case (it.cmd)
            CMD_START:
            begin
                m        = (sw > sh) ? sw : sh;
                img_w    = IMG_W'(sw * t / m);
                img_h    = IMG_W'(sh * t / m);
                pad_left = CNT_W'((t - sw * t / m) / 2);
                pad_top  = CNT_W'((t - sh * t / m) / 2);
                inv_step = INV_W'((m << FRAC_BITS) / t);
                col_n    = '0;
                row_n    = '0;
                col_acc  = '0;
                row_acc  = '0;
                pad_latch = 1'b1;
                r.scale_q16    = SCALE_W'(((t << FRAC_BITS) + m / 2) / m);
                r.offset_x_q16 = OFFSET_W'((((t * (m - sw)) << FRAC_BITS) + m) / (2 * m));
                r.offset_y_q16 = OFFSET_W'((((t * (m - sh)) << FRAC_BITS) + m) / (2 * m));
                return 1'b1;
            end
            CMD_WALK:
            begin
                x       = col_n;
                y       = row_n;
                in_col  = (x >= pad_left) && (x < pad_left + img_w);
                in_row  = (y >= pad_top) && (y < pad_top + img_h);
                pad     = !(in_col && in_row);
                end_row = (x + 1 >= t);
                at_last = end_row && (y + 1 >= t);
                fx = 0;
                fy = 0;
                if (!pad)
                begin
                    fx = col_acc >> FRAC_BITS;
                    fy = row_acc >> FRAC_BITS;
                    if (fx > sw - 1)
                    begin
                        fx = sw - 1;
                    end
                    if (fy > sh - 1)
                    begin
                        fy = sh - 1;
                    end
                end
                r.dest_x  = CNT_W'(x);
                r.dest_y  = CNT_W'(y);
                r.is_pad  = pad;
                r.fetch_x = FETCH_W'(fx);
                r.fetch_y = FETCH_W'(fy);
                r.last    = at_last;
                if (in_col)
                begin
                    col_acc = col_acc + inv_step;
                end
                if (end_row)
                begin
                    col_n   = '0;
                    col_acc = '0;
                    if (in_row)
                    begin
                        row_acc = row_acc + inv_step;
                    end
                    if (at_last)
                    begin
                        row_n   = '0;
                        row_acc = '0;
                    end
                    else
                    begin
                        row_n = row_n + 1'b1;
                    end
                end
                else
                begin
                    col_n = col_n + 1'b1;
                end
                pad_latch = pad;
                return 1'b1;
            end
            CMD_DATA:
            begin
                if (pad_latch)
                begin
                    r.norm_red   = PIX_BIAS;
                    r.norm_green = PIX_BIAS;
                    r.norm_blue  = PIX_BIAS;
                end
                else
                begin
                    r.norm_red   = it.pix_red ^ PIX_BIAS;
                    r.norm_green = it.pix_green ^ PIX_BIAS;
                    r.norm_blue  = it.pix_blue ^ PIX_BIAS;
                end
                return 1'b1;
            end
            default:
            begin
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (got !== want)
        begin
            err_count++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    function automatic void compare_rsp(input lrn_rsp_t want, input lrn_rsp_t got);
        cmp_field("dest_x", want.dest_x, got.dest_x);
        cmp_field("dest_y", want.dest_y, got.dest_y);
        cmp_field("is_pad", want.is_pad, got.is_pad);
        cmp_field("fetch_x", want.fetch_x, got.fetch_x);
        cmp_field("fetch_y", want.fetch_y, got.fetch_y);
        cmp_field("last", want.last, got.last);
        cmp_field("norm_red", want.norm_red, got.norm_red);
        cmp_field("norm_green", want.norm_green, got.norm_green);
        cmp_field("norm_blue", want.norm_blue, got.norm_blue);
        cmp_field("scale_q16", want.scale_q16, got.scale_q16);
        cmp_field("offset_x_q16", want.offset_x_q16, got.offset_x_q16);
        cmp_field("offset_y_q16", want.offset_y_q16, got.offset_y_q16);
    endfunction

    function automatic lrn_req_t make_req(input logic [CMD_W-1:0] cmd);
        lrn_req_t it;
        it.cmd       = cmd;
        it.pix_red   = PIX_W'($urandom_range(0, 255));
        it.pix_green = PIX_W'($urandom_range(0, 255));
        it.pix_blue  = PIX_W'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic dir_row_t cmd_row(input logic [CMD_W-1:0] cmd,
                                         input logic [PIX_W-1:0] red, green, blue,
                                         input bit typed, input lrn_rsp_t want);
        dir_row_t row;
        row       = '{kind: ROW_CMD, default: '0};
        row.item  = '{cmd: cmd, pix_red: red, pix_green: green, pix_blue: blue};
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(input logic [2:0] mask,
                                         input logic [CFG_DATA_W-1:0] w, h, t);
        dir_row_t row;
        row       = '{kind: ROW_CFG, default: '0};
        row.mask  = mask;
        row.w_val = w;
        row.h_val = h;
        row.t_val = t;
        return row;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_source();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return CFG_DATA_W'($urandom_range(MAX_SOURCE + 1, 8191));
            2: return CFG_DATA_W'(MAX_SOURCE);
            3: return CFG_DATA_W'($urandom_range(41, MAX_SOURCE - 1));
            default: return CFG_DATA_W'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_side();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return CFG_DATA_W'(MAX_TARGET);
            2: return CFG_DATA_W'($urandom_range(MAX_TARGET + 1, 8191));
            3: return CFG_DATA_W'($urandom_range(13, MAX_TARGET - 1));
            4, 5: return CFG_DATA_W'($urandom_range(7, 12));
            default: return CFG_DATA_W'($urandom_range(1, 6));
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_req(input lrn_req_t item, input bit typed, input lrn_rsp_t want);
        int gap;
        lrn_rsp_t pred;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= item;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        if (resample_predict(item, pred))
        begin
            due_rsp_q.push_back(typed ? want : pred);
        end
        case (item.cmd)
            CMD_START: n_start++;
            CMD_WALK:  n_walk++;
            CMD_DATA:  n_data++;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // sender pauses until every due result is back, then lets a dropped command settle
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (due_rsp_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_SOURCE_WIDTH:  reg_w = val[SRC_W-1:0];
            REG_SOURCE_HEIGHT: reg_h = val[SRC_W-1:0];
            REG_TARGET_SIDE:   reg_t = val[TGT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_regs(input logic [2:0] mask, input logic [CFG_DATA_W-1:0] w, h, t);
        drain_results();
        if (mask[0])
        begin
            write_reg(REG_SOURCE_WIDTH, w);
        end
        if (mask[1])
        begin
            write_reg(REG_SOURCE_HEIGHT, h);
        end
        if (mask[2])
        begin
            write_reg(REG_TARGET_SIDE, t);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin : rsp_side
        int stall;
        int hold;
        lrn_rsp_t want;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
            rsp_beats++;
            if (due_rsp_q.size() == 0)
            begin
                err_count++;
                $display("%0t: result beat with nothing due, expected none, got %p",
                         $time, rsp_ch.payload);
            end
            else
            begin
                want = due_rsp_q.pop_front();
                compare_rsp(want, rsp_ch.payload);
            end
        end
    end

    initial
    begin : req_side
        dir_row_t dir_tab [$];
        lrn_rsp_t e;
        int rand_items;
        int walks;
        longint unsigned side;
        logic [2:0] mask;

        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        reg_w     = SOURCE_WIDTH_RST;
        reg_h     = SOURCE_HEIGHT_RST;
        reg_t     = TARGET_SIDE_RST;
        img_w     = '0;
        img_h     = '0;
        pad_left  = '0;
        pad_top   = '0;
        inv_step  = '0;
        col_n     = '0;
        row_n     = '0;
        col_acc   = '0;
        row_acc   = '0;
        pad_latch = 1'b1;
        err_count = 0;
        rsp_beats = 0;
        n_start   = 0;
        n_walk    = 0;
        n_data    = 0;
        n_phase   = 0;
        rx_hold_cycles = 0;
        no_idle   = 1'b0;
        rand_items = 0;

        // data and walk before any start read as pad
        e = '0;
        e.norm_red   = PIX_BIAS;
        e.norm_green = PIX_BIAS;
        e.norm_blue  = PIX_BIAS;
        dir_tab.push_back(cmd_row(CMD_DATA, 8'hff, 8'hff, 8'hff, 1'b1, e));
        e = '0;
        e.is_pad = 1'b1;
        dir_tab.push_back(cmd_row(CMD_WALK, 8'h00, 8'h00, 8'h00, 1'b1, e));
        dir_tab.push_back(cmd_row(CMD_UNUSED, 8'h55, 8'haa, 8'h0f, 1'b0, '0));
        // reset setting: 640x480 into 640, 80 rows of pad top and bottom
        e = '0;
        e.scale_q16    = 27'd65536;
        e.offset_y_q16 = 26'd5242880;
        dir_tab.push_back(cmd_row(CMD_START, 8'h00, 8'h00, 8'h00, 1'b1, e));
        dir_tab.push_back(cmd_row(CMD_WALK, 8'h00, 8'h00, 8'h00, 1'b0, '0));
        dir_tab.push_back(cmd_row(CMD_DATA, 8'hff, 8'h00, 8'h7f, 1'b0, '0));
        // largest scale: 1x1 source blown up to 1024
        dir_tab.push_back(cfg_row(3'b111, 13'd1, 13'd1, 13'd1024));
        e = '0;
        e.scale_q16 = 27'd67108864;
        dir_tab.push_back(cmd_row(CMD_START, 8'h00, 8'h00, 8'h00, 1'b1, e));
        dir_tab.push_back(cmd_row(CMD_WALK, 8'h00, 8'h00, 8'h00, 1'b0, '0));
        dir_tab.push_back(cmd_row(CMD_DATA, 8'h00, 8'hff, 8'h80, 1'b0, '0));
        // width 0 reads as 1, height and side above the limits clamp
        dir_tab.push_back(cfg_row(3'b111, 13'd0, 13'd8191, 13'd2047));
        e = '0;
        e.scale_q16    = 27'd16384;
        e.offset_x_q16 = 26'd33546240;
        dir_tab.push_back(cmd_row(CMD_START, 8'h00, 8'h00, 8'h00, 1'b1, e));
        dir_tab.push_back(cmd_row(CMD_WALK, 8'h00, 8'h00, 8'h00, 1'b0, '0));
        dir_tab.push_back(cmd_row(CMD_DATA, 8'h12, 8'h34, 8'h56, 1'b0, '0));
        // side 0 reads as 1: one pixel frame, every walk is last and wraps
        dir_tab.push_back(cfg_row(3'b111, 13'd3, 13'd3, 13'd0));
        e = '0;
        e.scale_q16 = 27'd21845;
        dir_tab.push_back(cmd_row(CMD_START, 8'h00, 8'h00, 8'h00, 1'b1, e));
        e = '0;
        e.last = 1'b1;
        dir_tab.push_back(cmd_row(CMD_WALK, 8'h00, 8'h00, 8'h00, 1'b1, e));
        dir_tab.push_back(cmd_row(CMD_WALK, 8'h00, 8'h00, 8'h00, 1'b0, '0));
        dir_tab.push_back(cmd_row(CMD_DATA, 8'ha5, 8'h5a, 8'h01, 1'b0, '0));

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
            begin
                set_regs(dir_tab[i].mask, dir_tab[i].w_val, dir_tab[i].h_val,
                         dir_tab[i].t_val);
            end
            else
            begin
                send_req(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
            end
        end

        // random frames; a phase without a start keeps walking the old frame
        // under new registers, which also covers a side shrunk mid-frame
        while (rand_items < RAND_ITEMS)
        begin
            n_phase++;
            no_idle = ($urandom_range(0, 4) == 0);
            if (n_phase == 1)
            begin
                set_regs(3'b111, 13'd8, 13'd6, 13'd8);
            end
            else
            begin
                mask = 3'($urandom_range(0, 7));
                set_regs(mask, pick_source(), pick_source(), pick_side());
            end
            side = dim_eff(reg_t, MAX_TARGET);
            if (n_phase == 1 || $urandom_range(0, 7) != 0)
            begin
                send_req(make_req(CMD_START), 1'b0, '0);
                rand_items++;
            end
            // receiver sits out a long stretch while walks keep coming
            if (n_phase == 1)
            begin
                rx_hold_cycles = HOLD_CYC;
            end
            if (side > 12)
            begin
                walks = $urandom_range(1, 24);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                walks = $urandom_range(1, int'(side * side));
            end
            else
            begin
                walks = int'(side * side) + $urandom_range(0, 3);
            end
            for (int k = 0; k < walks && rand_items < RAND_ITEMS; k++)
            begin
                send_req(make_req(CMD_WALK), 1'b0, '0);
                rand_items++;
                if ($urandom_range(0, 3) != 0)
                begin
                    send_req(make_req(CMD_DATA), 1'b0, '0);
                    rand_items++;
                end
                if ($urandom_range(0, 19) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: send_req(make_req(CMD_UNUSED), 1'b0, '0);
                        1:
                        begin
                            send_req(make_req(CMD_DATA), 1'b0, '0);
                            rand_items++;
                        end
                        default:
                        begin
                            send_req(make_req(CMD_START), 1'b0, '0);
                            rand_items++;
                        end
                    endcase
                end
            end
        end

        drain_results();
        repeat (16) @(posedge clk);
        $display("covered %0d starts, %0d walks, %0d data beats over %0d register phases",
                 n_start, n_walk, n_data, n_phase);
        $display("checked %0d result beats, %0d field errors", rsp_beats, err_count);
        if (err_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
